FILE: design/chc_pkg.sv
// Shared types, widths and constants of the compass heading core.
package chc_pkg;

   // Number of vectoring micro-rotations; step counts above 32 act as 32.
   localparam int CORDIC_STEPS = 18;
   localparam int MAX_STEPS    = 32;
   localparam int NUM_STEPS    = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;

   // Vector carries 20 fractional bits below the 17-bit magnitude plus CORDIC growth.
   localparam int VEC_SHIFT = 20;
   localparam int VEC_W     = 40;
   // Accumulated angle, signed Q16 scaled degrees.
   localparam int Z_W       = 25;
   localparam int ATAN_W    = 24;
   localparam int Q_W       = 23;
   localparam int H_W       = 26;
   localparam int DEG_W     = 9;

   localparam logic [Q_W-1:0] QUARTER_Q16 = 23'd5898232;
   localparam logic [H_W-1:0] FULL_Q16    = 26'd23592960;
   localparam logic [DEG_W:0] DEG_MAX     = 10'd359;

   // Register indexes of the configuration port.
   localparam logic REG_X_OFFSET = 1'b0;
   localparam logic REG_Y_OFFSET = 1'b1;

   localparam logic signed [15:0] X_OFFSET_RESET = 16'sd213;
   localparam logic signed [15:0] Y_OFFSET_RESET = -16'sd251;

   // atan(2^-i) in Q16 degrees with the 57.2957 radian factor.
   localparam logic [ATAN_W-1:0] ATAN_TAB [0:MAX_STEPS] = '{
      24'd2949116, 24'd1740965, 24'd919878, 24'd466944, 24'd234378, 24'd117303,
      24'd58666, 24'd29335, 24'd14668, 24'd7334, 24'd3667, 24'd1833, 24'd917,
      24'd458, 24'd229, 24'd115, 24'd57, 24'd29, 24'd14, 24'd7, 24'd4, 24'd2,
      24'd1, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0,
      24'd0
   };

   // Per-transaction flags that ride alongside the vector.
   typedef struct packed {
      logic zero_vec;
      logic b_zero;
      logic swapped;
      logic x_neg;
      logic y_neg;
   } chc_side_type;

endpackage

FILE: design/chc_prep.sv
// Offset correction, absolute value and octant folding, three register stages.
module chc_prep
   import chc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic signed [15:0]      raw_x,
   input  logic signed [15:0]      raw_y,
   input  logic signed [15:0]      x_offset,
   input  logic signed [15:0]      y_offset,
   output logic                    out_valid,
   output logic signed [VEC_W-1:0] out_vx,
   output logic signed [VEC_W-1:0] out_vy,
   output chc_side_type            out_side
);

   logic                    v1_ff, v2_ff, v3_ff;
   logic signed [15:0]      cx_ff, cy_ff;
   logic signed [15:0]      cx_in, cy_in;
   logic [16:0]             ax_ff, ay_ff, ax_in, ay_in;
   logic                    xn2_ff, yn2_ff, zv2_ff;
   logic signed [VEC_W-1:0] vx_ff, vy_ff, vx_in, vy_in;
   chc_side_type            side_ff, side_in;

   // Stage one: hard-iron correction wraps in 16 bits.
   assign cx_in = raw_x - x_offset;
   assign cy_in = raw_y - y_offset;

   // Stage two: magnitudes in 17 bits so that -32768 is representable.
   always_comb begin
      ax_in = cx_ff[15] ? (17'd0 - {1'b1, cx_ff}) : {1'b0, cx_ff};
      ay_in = cy_ff[15] ? (17'd0 - {1'b1, cy_ff}) : {1'b0, cy_ff};
   end

   // Stage three: fold into the first octant and scale up.
   always_comb begin
      side_in.zero_vec = zv2_ff;
      side_in.x_neg    = xn2_ff;
      side_in.y_neg    = yn2_ff;
      side_in.swapped  = (ay_ff > ax_ff);
      if (ay_ff > ax_ff) begin
         vx_in          = $signed({3'b000, ay_ff, {VEC_SHIFT{1'b0}}});
         vy_in          = $signed({3'b000, ax_ff, {VEC_SHIFT{1'b0}}});
         side_in.b_zero = (ax_ff == 17'd0);
      end else begin
         vx_in          = $signed({3'b000, ax_ff, {VEC_SHIFT{1'b0}}});
         vy_in          = $signed({3'b000, ay_ff, {VEC_SHIFT{1'b0}}});
         side_in.b_zero = (ay_ff == 17'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      ax_ff   <= ax_in;
      ay_ff   <= ay_in;
      xn2_ff  <= cx_ff[15];
      yn2_ff  <= cy_ff[15];
      zv2_ff  <= (cx_ff == 16'sd0) && (cy_ff == 16'sd0);
      vx_ff   <= vx_in;
      vy_ff   <= vy_in;
      side_ff <= side_in;
   end

   assign out_valid = v3_ff;
   assign out_vx    = vx_ff;
   assign out_vy    = vy_ff;
   assign out_side  = side_ff;

endmodule

FILE: design/chc_cordic.sv
// Vectoring CORDIC, one registered micro-rotation per stage.
module chc_cordic
   import chc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic signed [VEC_W-1:0] in_vx,
   input  logic signed [VEC_W-1:0] in_vy,
   input  chc_side_type            in_side,
   output logic                    out_valid,
   output logic signed [Z_W-1:0]   out_z,
   output chc_side_type            out_side
);

   logic                    valid_ff [1:NUM_STEPS];
   logic signed [VEC_W-1:0] vx_ff    [1:NUM_STEPS];
   logic signed [VEC_W-1:0] vy_ff    [1:NUM_STEPS];
   logic signed [Z_W-1:0]   z_ff     [1:NUM_STEPS];
   chc_side_type            side_ff  [1:NUM_STEPS];

   for (genvar k = 1; k <= NUM_STEPS; k++) begin : g_step
      logic                    valid_prev;
      logic signed [VEC_W-1:0] vx_prev, vy_prev, dx, dy, vx_in, vy_in;
      logic signed [Z_W-1:0]   z_prev, da, z_in;
      chc_side_type            side_prev;

      // The first rotation takes the fold stage registers directly.
      if (k == 1) begin : g_head
         assign valid_prev = in_valid;
         assign vx_prev    = in_vx;
         assign vy_prev    = in_vy;
         assign z_prev     = '0;
         assign side_prev  = in_side;
      end else begin : g_link
         assign valid_prev = valid_ff[k-1];
         assign vx_prev    = vx_ff[k-1];
         assign vy_prev    = vy_ff[k-1];
         assign z_prev     = z_ff[k-1];
         assign side_prev  = side_ff[k-1];
      end

      always_comb begin
         dx = vy_prev >>> k;
         dy = vx_prev >>> k;
         da = $signed({{(Z_W-ATAN_W){1'b0}}, ATAN_TAB[k]});
         if (!vy_prev[VEC_W-1]) begin
            vx_in = vx_prev + dx;
            vy_in = vy_prev - dy;
            z_in  = z_prev + da;
         end else begin
            vx_in = vx_prev - dx;
            vy_in = vy_prev + dy;
            z_in  = z_prev - da;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         vx_ff[k]   <= vx_in;
         vy_ff[k]   <= vy_in;
         z_ff[k]    <= z_in;
         side_ff[k] <= side_prev;
      end
   end

   assign out_valid = valid_ff[NUM_STEPS];
   assign out_z     = z_ff[NUM_STEPS];
   assign out_side  = side_ff[NUM_STEPS];

endmodule

FILE: design/chc_finish.sv
// Octant clamp, quadrant mapping and whole-degree result, two register stages.
module chc_finish
   import chc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic signed [Z_W-1:0] in_z,
   input  chc_side_type          in_side,
   output logic                  out_valid,
   output logic [DEG_W-1:0]      out_deg
);

   logic                 v1_ff, v2_ff;
   logic [Q_W-1:0]       q_ff, q_in;
   logic [Q_W-1:0]       oct;
   chc_side_type         side_ff;
   logic [DEG_W-1:0]     deg_ff, deg_in;
   logic [H_W-1:0]       h, q_ext, quarter_ext;
   logic [DEG_W:0]       deg_raw;

   // Stage one: clamp the octant angle, then reflect about 45 degrees if folded.
   always_comb begin
      if (in_side.b_zero || in_z[Z_W-1]) begin
         oct = '0;
      end else if (in_z > $signed({{(Z_W-ATAN_W){1'b0}}, ATAN_TAB[0]})) begin
         oct = ATAN_TAB[0][Q_W-1:0];
      end else begin
         oct = in_z[Q_W-1:0];
      end
      q_in = in_side.swapped ? (QUARTER_Q16 - oct) : oct;
   end

   // Stage two: place the angle in its quadrant and truncate to degrees.
   always_comb begin
      q_ext       = {{(H_W-Q_W){1'b0}}, q_ff};
      quarter_ext = {{(H_W-Q_W){1'b0}}, QUARTER_Q16};
      if (!side_ff.y_neg) begin
         h = side_ff.x_neg ? ((quarter_ext << 1) - q_ext) : q_ext;
      end else begin
         h = side_ff.x_neg ? (FULL_Q16 - (quarter_ext << 1) + q_ext) : (FULL_Q16 - q_ext);
      end
      deg_raw = h[H_W-1:16];
      if (side_ff.zero_vec) begin
         deg_in = '0;
      end else if (deg_raw > DEG_MAX) begin
         deg_in = DEG_MAX[DEG_W-1:0];
      end else begin
         deg_in = deg_raw[DEG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      q_ff    <= q_in;
      side_ff <= in_side;
      deg_ff  <= deg_in;
   end

   assign out_valid = v2_ff;
   assign out_deg   = deg_ff;

endmodule

FILE: design/compass_heading_from_xy_core.sv
// Top level of the compass heading core: register port and pipeline assembly.
//
// This core turns one raw magnetometer X/Y sample into a compass heading in
// whole degrees (0 to 359), measured from corrected X toward corrected Y.
// A transaction is accepted on every clock edge where start is high; busy is
// never raised, so a new sample may be issued every cycle. Each result appears
// on rsp_heading_deg for exactly one cycle with rsp_valid high, once its
// sample has passed the registered offset correction and octant folding
// stages, the registered CORDIC micro-rotations (18 of them), and
// quadrant mapping. The receiver cannot stall the core and must take each
// result in the cycle it is shown. Results come out in the order the samples
// went in. The hard-iron offsets live at byte addresses 0 (X) and 4 (Y) of the
// register port; they reset to 213 and -251 and should be written only while
// no transaction is in flight. A corrected vector of (0,0) yields heading 0.
// Headings that lie within the CORDIC error of a degree boundary may differ by
// one from an exact computation.
module compass_heading_from_xy_core
   import chc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // Sample channel.
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_raw_x,
   input  logic signed [15:0] req_raw_y,
   // Result channel.
   output logic               rsp_valid,
   output logic [DEG_W-1:0]   rsp_heading_deg,
   // Register port.
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   logic signed [15:0]      x_offset_ff, y_offset_ff;
   logic                    csr_write;
   logic                    prep_valid, cordic_valid;
   logic signed [VEC_W-1:0] prep_vx, prep_vy;
   chc_side_type            prep_side, cordic_side;
   logic signed [Z_W-1:0]   cordic_z;

   // The pipeline never stalls, so the sample side is always open.
   assign busy   = 1'b0;
   assign pready = 1'b1;

   // Register index sits in address bit 2; the low bits select nothing.
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_offset_ff <= X_OFFSET_RESET;
         y_offset_ff <= Y_OFFSET_RESET;
      end else if (csr_write) begin
         unique case (paddr[2])
            REG_X_OFFSET: x_offset_ff <= pwdata[15:0];
            REG_Y_OFFSET: y_offset_ff <= pwdata[15:0];
            default:      x_offset_ff <= x_offset_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_X_OFFSET: prdata = {16'd0, x_offset_ff};
         REG_Y_OFFSET: prdata = {16'd0, y_offset_ff};
         default:      prdata = '0;
      endcase
   end

   chc_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .raw_x     (req_raw_x),
      .raw_y     (req_raw_y),
      .x_offset  (x_offset_ff),
      .y_offset  (y_offset_ff),
      .out_valid (prep_valid),
      .out_vx    (prep_vx),
      .out_vy    (prep_vy),
      .out_side  (prep_side)
   );

   chc_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid),
      .in_vx     (prep_vx),
      .in_vy     (prep_vy),
      .in_side   (prep_side),
      .out_valid (cordic_valid),
      .out_z     (cordic_z),
      .out_side  (cordic_side)
   );

   chc_finish u_finish (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cordic_valid),
      .in_z      (cordic_z),
      .in_side   (cordic_side),
      .out_valid (rsp_valid),
      .out_deg   (rsp_heading_deg)
   );

endmodule

FILE: tb/sv/tb_compass_heading_from_xy_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for the compass heading core, with a bit-exact CORDIC predictor.
module tb_compass_heading_from_xy_core;
   import chc_pkg::*;

   // The predictor keeps its own copy of the arithmetic constants. It does not
   // reuse the ones in the package, so an error in the table there shows up as
   // a mismatch instead of being repeated by the checker.
   localparam int     ROTATIONS    = 18;
   localparam int     VEC_FRAC     = 20;
   localparam longint QUARTER_TURN = 5898232;
   localparam longint FULL_TURN    = 360 * 65536;
   localparam longint ARCTAN_Q16 [0:32] = '{
      2949116, 1740965, 919878, 466944, 234378, 117303, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0,
      0, 0, 0, 0, 0, 0, 0, 0,
      0
   };

   localparam logic signed [15:0] X_OFF_AT_RESET = 16'sd213;
   localparam logic signed [15:0] Y_OFF_AT_RESET = -16'sd251;
   localparam logic [2:0] X_OFFSET_ADDR = {REG_X_OFFSET, 2'b00};
   localparam logic [2:0] Y_OFFSET_ADDR = {REG_Y_OFFSET, 2'b00};

   localparam int PIPE_LATENCY    = 23;
   localparam int NUM_PHASES      = 7;
   localparam int ITEMS_PER_PHASE = 150;
   localparam int TIMEOUT_CYCLES  = 200000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [15:0] req_raw_x = '0;
   logic signed [15:0] req_raw_y = '0;
   logic               rsp_valid;
   logic [DEG_W-1:0]   rsp_heading_deg;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [2:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   // The offsets currently held by the core, tracked from the register writes it accepts.
   logic signed [15:0] cur_x_offset = X_OFF_AT_RESET;
   logic signed [15:0] cur_y_offset = Y_OFF_AT_RESET;

   // Headings predicted for accepted samples, oldest first.
   logic [DEG_W-1:0]   pending_headings[$];

   int fail_count      = 0;
   int samples_sent    = 0;
   int headings_seen   = 0;
   int offset_settings = 0;

   compass_heading_from_xy_core uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_raw_x       (req_raw_x),
      .req_raw_y       (req_raw_y),
      .rsp_valid       (rsp_valid),
      .rsp_heading_deg (rsp_heading_deg),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Heading of one raw sample under the given offsets. The corrected vector is
   // folded into the first octant, an 18-step vectoring CORDIC finds its angle
   // in Q16 scaled degrees, and the angle is unfolded to the full circle.
   function automatic logic [DEG_W-1:0] predict_heading(
      input logic [15:0] raw_x, input logic [15:0] raw_y,
      input logic [15:0] x_off, input logic [15:0] y_off);
      logic signed [15:0] cx;
      logic signed [15:0] cy;
      longint ax, ay, tmp, vx, vy, dx, dy, z, q, h;
      bit swapped;
      int step;
      cx = raw_x - x_off;
      cy = raw_y - y_off;
      if (cx == 0 && cy == 0)
         return '0;
      ax = (cx < 0) ? -longint'(cx) : longint'(cx);
      ay = (cy < 0) ? -longint'(cy) : longint'(cy);
      swapped = 1'b0;
      if (ay > ax) begin
         tmp = ax;
         ax = ay;
         ay = tmp;
         swapped = 1'b1;
      end
      z = 0;
      // A vector on an axis has an octant angle of exactly zero.
      if (ay != 0) begin
         vx = ax <<< VEC_FRAC;
         vy = ay <<< VEC_FRAC;
         for (step = 1; step <= ROTATIONS; step++) begin
            // Arithmetic shifts round toward minus infinity, as the core does.
            dx = vy >>> step;
            dy = vx >>> step;
            if (vy >= 0) begin
               vx += dx;
               vy -= dy;
               z += ARCTAN_Q16[step];
            end else begin
               vx -= dx;
               vy += dy;
               z -= ARCTAN_Q16[step];
            end
         end
         if (z < 0)
            z = 0;
         if (z > ARCTAN_Q16[0])
            z = ARCTAN_Q16[0];
      end
      q = swapped ? QUARTER_TURN - z : z;
      if (cy >= 0)
         h = (cx >= 0) ? q : 2 * QUARTER_TURN - q;
      else
         h = (cx >= 0) ? FULL_TURN - q : FULL_TURN - 2 * QUARTER_TURN + q;
      if (h < 0)
         h = 0;
      h = h >>> 16;
      // A heading that would reach 360 is held at 359.
      if (h > 359)
         h = 359;
      return DEG_W'(h);
   endfunction

   // Monitor: tracks register writes, predicts each accepted sample and checks
   // every result against the oldest prediction. Everything is sampled at the
   // rising edge, before the nonblocking updates of that edge land.
   always @(posedge clock) begin
      if (reset) begin
         cur_x_offset = X_OFF_AT_RESET;
         cur_y_offset = Y_OFF_AT_RESET;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr)
               X_OFFSET_ADDR: cur_x_offset = pwdata[15:0];
               Y_OFFSET_ADDR: cur_y_offset = pwdata[15:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            pending_headings.push_back(
               predict_heading(req_raw_x, req_raw_y, cur_x_offset, cur_y_offset));
            samples_sent++;
         end
         if (rsp_valid) begin
            headings_seen++;
            if (pending_headings.size() == 0) begin
               $error("heading_deg: result with no transaction pending, expected none, actual %0d",
                      rsp_heading_deg);
               fail_count++;
            end else if (rsp_heading_deg !== pending_headings[0]) begin
               $error("heading_deg mismatch: expected %0d, actual %0d",
                      pending_headings[0], rsp_heading_deg);
               fail_count++;
               void'(pending_headings.pop_front());
            end else begin
               void'(pending_headings.pop_front());
            end
         end
      end
   end

   // Issues one sample and returns at the edge where the core accepts it.
   // Start stays high, so back-to-back calls stream one transaction per cycle.
   task automatic send_sample(input logic signed [15:0] raw_x, input logic signed [15:0] raw_y);
      start     <= 1'b1;
      req_raw_x <= raw_x;
      req_raw_y <= raw_y;
      do @(posedge clock); while (busy);
   endtask

   // Issues the raw sample that corrects to the given vector under the current offsets.
   task automatic send_corrected(input logic signed [15:0] cx, input logic signed [15:0] cy);
      send_sample(cx + cur_x_offset, cy + cur_y_offset);
   endtask

   task automatic hold_off(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Stops issuing and waits until every predicted heading has come back.
   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (pending_headings.size() != 0)
         @(posedge clock);
      @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic signed [15:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= {{16{value[15]}}, value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Reads one offset register back; only the low 16 bits carry the value.
   task automatic csr_read_check(input logic [2:0] addr, input logic [15:0] expected,
                                 input string field);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[15:0] !== expected) begin
         $error("%s readback mismatch: expected %0d, actual %0d",
                field, $signed(expected), $signed(prdata[15:0]));
         fail_count++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Writes both offsets and reads them back. Only called with the core idle.
   task automatic program_offsets(input logic signed [15:0] x_off, input logic signed [15:0] y_off);
      csr_write(X_OFFSET_ADDR, x_off);
      csr_write(Y_OFFSET_ADDR, y_off);
      csr_read_check(X_OFFSET_ADDR, x_off, "x_offset");
      csr_read_check(Y_OFFSET_ADDR, y_off, "y_offset");
      offset_settings++;
   endtask

   // Reset offsets, the zero vector, the four axes, the unit diagonals, points
   // next to the axes and three corners of the range, issued back to back.
   task automatic test_special_vectors();
      csr_read_check(X_OFFSET_ADDR, X_OFF_AT_RESET, "x_offset");
      csr_read_check(Y_OFFSET_ADDR, Y_OFF_AT_RESET, "y_offset");
      offset_settings++;
      send_corrected(16'sd0, 16'sd0);
      send_corrected(16'sd1000, 16'sd0);
      send_corrected(16'sd0, 16'sd1000);
      send_corrected(-16'sd1000, 16'sd0);
      send_corrected(16'sd0, -16'sd1000);
      send_corrected(16'sd1, 16'sd1);
      send_corrected(-16'sd1, -16'sd1);
      send_corrected(16'sd32767, 16'sd32767);
      // Just below the positive X axis, where the heading is closest to 360.
      send_corrected(16'sd32767, -16'sd1);
      send_corrected(-16'sd32768, -16'sd1);
      send_corrected(-16'sd32768, 16'sd0);
      send_corrected(-16'sd32768, -16'sd32768);
      send_corrected(16'sd32767, -16'sd32768);
      wait_idle();
   endtask

   // Zero and extreme offsets, with samples that wrap when corrected.
   task automatic test_offset_extremes();
      int k;
      for (k = 0; k < 3; k++) begin
         case (k)
            0:       program_offsets(16'sd0, 16'sd0);
            1:       program_offsets(-16'sd32768, 16'sd32767);
            default: program_offsets(16'sd32767, -16'sd32768);
         endcase
         send_corrected(16'sd0, 16'sd0);
         send_corrected(-16'sd32768, -16'sd32768);
         send_corrected(16'sd32767, 16'sd1);
         send_sample(-16'sd32768, 16'sd32767);
         wait_idle();
      end
   endtask

   // Random samples in bursts under a series of offset settings. The mix leans
   // on the places where the arithmetic turns: tiny vectors, axes, the
   // diagonal where the octant fold swaps, and the wrap at the range ends.
   task automatic test_random_streams();
      int phase;
      int sent;
      int burst;
      logic signed [15:0] cx;
      logic signed [15:0] cy;
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         wait_idle();
         case (phase)
            1:       program_offsets(16'sd0, 16'sd0);
            2:       program_offsets(-16'sd32768, -16'sd32768);
            3:       program_offsets(16'sd32767, 16'sd32767);
            5:       program_offsets(16'sd32767, -16'sd32768);
            default: program_offsets(16'($urandom), 16'($urandom));
         endcase
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            burst = $urandom_range(1, 24);
            // The last burst of a phase is trimmed so each phase sends exactly its share.
            if (burst > ITEMS_PER_PHASE - sent)
               burst = ITEMS_PER_PHASE - sent;
            repeat (burst) begin
               case ($urandom_range(0, 9))
                  4: begin
                     cx = 16'($urandom_range(0, 16)) - 16'd8;
                     cy = 16'($urandom_range(0, 16)) - 16'd8;
                  end
                  5: begin
                     cx = 16'($urandom);
                     cy = '0;
                     if ($urandom_range(0, 1)) begin
                        cy = cx;
                        cx = '0;
                     end
                  end
                  6, 7: begin
                     cx = 16'($urandom);
                     cy = cx + 16'($urandom_range(0, 6)) - 16'd3;
                     if ($urandom_range(0, 1))
                        cy = -cy;
                  end
                  8: begin
                     cx = ($urandom_range(0, 1) ? 16'h7FFF : 16'h8000)
                          + 16'($urandom_range(0, 2)) - 16'd1;
                     cy = ($urandom_range(0, 1) ? 16'h7FFF : 16'h8000)
                          + 16'($urandom_range(0, 2)) - 16'd1;
                  end
                  9: begin
                     cx = 16'($urandom);
                     cy = 16'($urandom_range(0, 4)) - 16'd2;
                     if ($urandom_range(0, 1)) begin
                        cy = cx;
                        cx = 16'($urandom_range(0, 4)) - 16'd2;
                     end
                  end
                  default: begin
                     // Fully random raw sample, independent of the offsets.
                     cx = 16'($urandom) - cur_x_offset;
                     cy = 16'($urandom) - cur_y_offset;
                  end
               endcase
               send_corrected(cx, cy);
               sent++;
            end
            // About a quarter of the bursts run straight into the next one.
            // Long gaps let the pipeline drain part way at every depth.
            if ($urandom_range(0, 3) != 0)
               hold_off(($urandom_range(0, 7) == 0) ? $urandom_range(9, 30)
                                                    : $urandom_range(1, 8));
         end
      end
      wait_idle();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_special_vectors();
      test_offset_extremes();
      test_random_streams();
      wait_idle();
      repeat (PIPE_LATENCY + 5) @(posedge clock);
      $display("Checked %0d headings from %0d samples under %0d offset settings.",
               headings_seen, samples_sent, offset_settings);
      $display("Covered zero, axis and corner vectors, wrapped corrections and bursty traffic.");
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // Watchdog: a correct run finishes well inside this many cycles.
   initial begin
      repeat (TIMEOUT_CYCLES) @(posedge clock);
      $display("Timeout with %0d headings still pending.", pending_headings.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule
